@@ rtl/sacf_pkg.sv @@
// Shared types and register codes for the set-associative FIFO tag store.
// No dependencies.
package sacf_pkg;

  localparam int ADDR_W    = 64;
  localparam int SET_W_MAX = 12;   // widest set index the store supports
  localparam int RAW_W     = 15;   // index field as cut from the address

  typedef enum logic [1:0] {
    CFG_BLOCK_OFFSET = 2'd0,
    CFG_SET_INDEX    = 2'd1,
    CFG_ALLOCATE     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0] block_offset_bits;
    logic [3:0] set_index_bits;
    logic       allocate_on_miss;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic [SET_W_MAX-1:0] set;
  } req_t;

endpackage

@@ rtl/sacf_if.sv @@
// Channel interfaces of the tag store: lookup, result and register write.
// No dependencies.
interface sacf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacf_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  hit_way;
  logic [7:0]  set_number;
  logic        evicted;
  logic [63:0] evicted_address;
  modport source (output valid, output hit, output hit_way, output set_number,
                  output evicted, output evicted_address, input ready);
  modport sink   (input valid, input hit, input hit_way, input set_number,
                  input evicted, input evicted_address, output ready);
endinterface

interface sacf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sacf_front.sv @@
// Front end: config registers, address intake and set index reduction.
// Depends on sacf_pkg and sacf_if.
module sacf_front #(
  parameter int SETS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           store_ready,
  sacf_in_if.sink        in_if,
  sacf_cfg_if.sink       cfg_if,
  output sacf_pkg::cfg_t cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output sacf_pkg::req_t push_data
);
  import sacf_pkg::*;

  // quotient estimate by reciprocal multiply, low by at most one
  localparam int                 QSH     = 27;
  localparam logic [QSH:0]       RECIP   = (QSH+1)'((1 << QSH) / SETS);
  localparam logic [RAW_W-1:0]   SETS_RW = RAW_W'(SETS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_QUO  = 4'b0010,
    F_RED  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t             st_r, st_nxt;
  cfg_t                cfg_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [RAW_W-1:0]    rem_r, rem_nxt;
  logic [RAW_W-1:0]    quo_r, quo_nxt;
  logic [ADDR_W-1:0]   shifted;
  logic [15:0]         idx_mask;
  logic [RAW_W-1:0]    raw;
  logic [RAW_W+QSH:0]  quo_prod;
  logic [2*RAW_W-1:0]  qs_full;
  logic [RAW_W-1:0]    diff;

  assign cfg          = cfg_r;
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (st_r == F_IDLE) && store_ready;
  assign push_valid   = (st_r == F_PUSH);
  assign push_data    = '{address: addr_r, set: rem_r[SET_W_MAX-1:0]};

  assign shifted  = in_if.address >> cfg_r.block_offset_bits;
  assign idx_mask = (16'h1 << cfg_r.set_index_bits) - 16'h1;
  assign raw      = shifted[RAW_W-1:0] & idx_mask[RAW_W-1:0];

  assign quo_prod = {{(QSH+1){1'b0}}, rem_r} * {{RAW_W{1'b0}}, RECIP};
  assign qs_full  = {{RAW_W{1'b0}}, quo_r} * {{RAW_W{1'b0}}, SETS_RW};
  assign diff     = rem_r - qs_full[RAW_W-1:0];

  always_comb begin
    st_nxt  = st_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    unique case (st_r)
      F_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          rem_nxt = raw;
          st_nxt  = F_QUO;
        end
      end
      F_QUO: begin
        quo_nxt = quo_prod[RAW_W+QSH-1:QSH];
        st_nxt  = F_RED;
      end
      F_RED: begin
        // remainder modulo SETS, one correction for the low estimate
        rem_nxt = (diff >= SETS_RW) ? diff - SETS_RW : diff;
        st_nxt  = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cfg_r <= '{block_offset_bits: 4'd6, set_index_bits: 4'd6, allocate_on_miss: 1'b1};
    end else begin
      st_r <= st_nxt;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_BLOCK_OFFSET: cfg_r.block_offset_bits <= cfg_if.data;
          CFG_SET_INDEX:    cfg_r.set_index_bits    <= cfg_if.data;
          CFG_ALLOCATE:     cfg_r.allocate_on_miss  <= cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (in_if.valid && in_if.ready) addr_r <= in_if.address;
  end

endmodule

@@ rtl/sacf_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on sacf_pkg.
module sacf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sacf_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sacf_pkg::req_t pop_data
);
  import sacf_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

@@ rtl/sacf_back.sv @@
// Back end: tag and state memories, way compare, FIFO fill, result register.
// Depends on sacf_pkg and sacf_if.
module sacf_back #(
  parameter int WAYS = 4,
  parameter int SETS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sacf_pkg::cfg_t cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  sacf_pkg::req_t pop_data,
  output logic           store_ready,
  sacf_out_if.source     out_if
);
  import sacf_pkg::*;

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int PW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW = WAYS * ADDR_W;
  localparam int MW = PW + WAYS;

  typedef enum logic [3:0] {
    B_CLR  = 4'b0001,
    B_IDLE = 4'b0010,
    B_CMP  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t           st_r;
  logic [SW-1:0]     clr_r;
  logic [TW-1:0]     tag_mem [SETS];
  logic [MW-1:0]     meta_mem [SETS];
  logic [TW-1:0]     rd_tag_r;
  logic [MW-1:0]     rd_meta_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SW-1:0]     set_r;

  logic              hit_r, ev_r;
  logic [1:0]        way_r;
  logic [7:0]        setn_r;
  logic [ADDR_W-1:0] eva_r;

  logic [WAYS-1:0]   valid_v, match, valid_new;
  logic [PW-1:0]     ptr, found, ptr_new;
  logic              any_hit, fill;
  logic [5:0]        shift;
  logic [ADDR_W-1:0] keep;
  logic [TW-1:0]     tag_new;
  logic [ADDR_W-1:0] victim_addr;
  logic              victim_valid;
  logic [SW-1:0]     rd_set;

  assign pop_ready   = (st_r == B_IDLE);
  assign store_ready = (st_r != B_CLR);
  assign rd_set      = pop_data.set[SW-1:0];

  assign valid_v = rd_meta_r[WAYS-1:0];
  assign ptr     = rd_meta_r[MW-1:WAYS];
  assign shift   = {2'b0, cfg.block_offset_bits} + {2'b0, cfg.set_index_bits};
  assign keep    = ~((64'h1 << shift) - 64'h1);

  always_comb begin
    found        = '0;
    any_hit      = 1'b0;
    tag_new      = rd_tag_r;
    valid_new    = valid_v;
    victim_addr  = '0;
    victim_valid = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_v[w] &&
                 (((rd_tag_r[w*ADDR_W +: ADDR_W] ^ addr_r) & keep) == '0);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        found   = PW'(w);
        any_hit = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (PW'(w) == ptr) begin
        victim_addr                = rd_tag_r[w*ADDR_W +: ADDR_W];
        victim_valid               = valid_v[w];
        tag_new[w*ADDR_W +: ADDR_W] = addr_r;
        valid_new[w]               = 1'b1;
      end
    end
    fill    = !any_hit && cfg.allocate_on_miss;
    ptr_new = (ptr == PW'(WAYS - 1)) ? '0 : ptr + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
    end else begin
      unique case (st_r)
        B_CLR: begin
          if (clr_r == SW'(SETS - 1)) st_r <= B_IDLE;
          clr_r <= clr_r + SW'(1);
        end
        B_IDLE: if (pop_valid) st_r <= B_CMP;
        B_CMP:  st_r <= B_OUT;
        B_OUT:  if (out_if.ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // memories: registered reads on pop, row write-back after compare
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && pop_valid) begin
      rd_tag_r  <= tag_mem[rd_set];
      rd_meta_r <= meta_mem[rd_set];
      addr_r    <= pop_data.address;
      set_r     <= rd_set;
    end
    if (st_r == B_CLR) meta_mem[clr_r] <= '0;
    else if (st_r == B_CMP && fill) meta_mem[set_r] <= {ptr_new, valid_new};
    if (st_r == B_CMP && fill) tag_mem[set_r] <= tag_new;
  end

  always_ff @(posedge clk) begin
    if (st_r == B_CMP) begin
      hit_r  <= any_hit;
      way_r  <= any_hit ? 2'(found) : (fill ? 2'(ptr) : 2'd0);
      setn_r <= 8'(set_r);
      ev_r   <= fill && victim_valid;
      eva_r  <= (fill && victim_valid) ? victim_addr : '0;
    end
  end

  assign out_if.valid           = (st_r == B_OUT);
  assign out_if.hit             = hit_r;
  assign out_if.hit_way         = way_r;
  assign out_if.set_number      = setn_r;
  assign out_if.evicted         = ev_r;
  assign out_if.evicted_address = eva_r;

  a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_CMP |=> st_r == B_OUT) else $error("compare stage stalled");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.hit |-> !out_if.evicted) else $error("eviction on hit");
  a_ev_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.evicted |-> out_if.evicted_address == '0)
    else $error("stray evicted address");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_CLR |-> !pop_ready) else $error("pop during clear");

endmodule

@@ rtl/set_assoc_cache_fifo_unit.sv @@
// Top level of the set-associative FIFO-replacement tag store.
// Depends on sacf_pkg, sacf_if, sacf_front, sacf_queue and sacf_back.
//
// Each address word is split into offset, set index and tag from the config
// registers; all WAYS of the set are compared at once and one result word
// comes back per lookup. An allocating miss fills the way at the set's FIFO
// pointer and reports any valid line it displaced. After reset the valid
// bits and FIFO pointers are swept clear, one set a cycle, so no lookup is
// taken until the sweep is done; register writes are taken throughout.
// In the front end a lookup passes through intake, reciprocal multiply
// for the set quotient, remainder modulo SETS with one correction step and
// hand-off to the queue; in the back end through registered memory read,
// compare and row write-back, and a result register held until taken.
// Front and back overlap through a two-word queue, but the front end takes
// no new address word until the last has gone to the queue. A result
// left waiting holds the back end, then the queue fills and the front end
// stops taking input.
// Registers should be written only while the block is quiet.
module set_assoc_cache_fifo_unit #(
  parameter int WAYS = 4,
  parameter int SETS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  sacf_in_if.sink    in_if,
  sacf_out_if.source out_if,
  sacf_cfg_if.sink   cfg_if
);
  import sacf_pkg::*;

  cfg_t cfg;
  logic store_ready;
  logic push_valid, push_ready;
  req_t push_data;
  logic pop_valid, pop_ready;
  req_t pop_data;

  // front: registers and set index
  sacf_front #(.SETS(SETS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .store_ready(store_ready),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  sacf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // back: tag store and result
  sacf_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .store_ready(store_ready),
    .out_if     (out_if)
  );

endmodule
